@@ hw/rtl/afpd_pkg.sv @@
// Package for the AM/FM/PM demodulator: shared constants, sequencer state type
// and the CORDIC arctangent table. No dependencies.
package afpd_pkg;

    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ANGLE_LEN         = 24;
    localparam int CNT_W             = 5;
    localparam int ACC_W             = 48;
    localparam int CORDIC_W          = 50;
    localparam int PHASE_W           = 16;
    localparam int GAIN_W            = 32;
    localparam int MAG_W             = 16;
    localparam int CFG_IDX_W         = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_GAIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_PHASE = 2'd2;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_LOAD
    } t_state;

    // atan(2^-k) in units of 2^-32 of a full turn
    function automatic logic [31:0] atan_cycles(input logic [CNT_W-1:0] k);
        logic [31:0] v;
        case (k)
            5'd0:    v = 32'h20000000;
            5'd1:    v = 32'h12E4051E;
            5'd2:    v = 32'h09FB385B;
            5'd3:    v = 32'h051111D4;
            5'd4:    v = 32'h028B0D43;
            5'd5:    v = 32'h0145D7E1;
            5'd6:    v = 32'h00A2F61E;
            5'd7:    v = 32'h00517C55;
            5'd8:    v = 32'h0028BE53;
            5'd9:    v = 32'h00145F2F;
            5'd10:   v = 32'h000A2F98;
            5'd11:   v = 32'h000517CC;
            5'd12:   v = 32'h00028BE6;
            5'd13:   v = 32'h000145F3;
            5'd14:   v = 32'h0000A2FA;
            5'd15:   v = 32'h0000517D;
            5'd16:   v = 32'h000028BE;
            5'd17:   v = 32'h0000145F;
            5'd18:   v = 32'h00000A30;
            5'd19:   v = 32'h00000518;
            5'd20:   v = 32'h0000028C;
            5'd21:   v = 32'h00000146;
            5'd22:   v = 32'h000000A3;
            5'd23:   v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/afpd_cordic.sv @@
// Iterative vectoring CORDIC, one micro-rotation per cycle; gives the phase
// of (I, Q) in signed Q0.16 cycles. Depends on afpd_pkg.
module afpd_cordic #(
    parameter int SAMPLE_BITS   = afpd_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = afpd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [SAMPLE_BITS-1:0]       i_i,
    input  logic [SAMPLE_BITS-1:0]       i_q,
    output logic                         o_done,
    output logic [afpd_pkg::PHASE_W-1:0] o_phase
);
    localparam int CW    = afpd_pkg::CORDIC_W;
    localparam int SHIFT = afpd_pkg::ACC_W - SAMPLE_BITS;
    localparam int NIT   = (CORDIC_STAGES < afpd_pkg::ANGLE_LEN) ?
                           CORDIC_STAGES : afpd_pkg::ANGLE_LEN;

    logic signed [CW-1:0]             r_x, r_y, n_x, n_y, xs, ys;
    logic [31:0]                      r_acc, n_acc, rnd;
    logic [afpd_pkg::CNT_W-1:0]       r_k;
    logic                             r_busy, r_done, r_zero;

    assign xs = CW'($signed(i_i)) <<< SHIFT;
    assign ys = CW'($signed(i_q)) <<< SHIFT;

    always_comb begin
        if (!r_y[CW-1] && (r_y != '0)) begin
            n_x   = r_x + (r_y >>> r_k);
            n_y   = r_y - (r_x >>> r_k);
            n_acc = r_acc + afpd_pkg::atan_cycles(r_k);
        end else begin
            n_x   = r_x - (r_y >>> r_k);
            n_y   = r_y + (r_x >>> r_k);
            n_acc = r_acc - afpd_pkg::atan_cycles(r_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_k == afpd_pkg::CNT_W'(NIT))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_zero <= (i_i == '0) && (i_q == '0);
            r_k    <= '0;
            if (xs[CW-1]) begin
                r_x   <= -xs;
                r_y   <= -ys;
                r_acc <= 32'h8000_0000;
            end else begin
                r_x   <= xs;
                r_y   <= ys;
                r_acc <= '0;
            end
        end else if (r_busy && (r_k != afpd_pkg::CNT_W'(NIT))) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_acc <= n_acc;
            r_k   <= r_k + 1'b1;
        end
    end

    assign rnd     = r_acc + 32'h0000_8000;
    assign o_phase = r_zero ? '0 : rnd[31:16];
    assign o_done  = r_done;

endmodule

@@ hw/rtl/afpd_sqrt.sv @@
// Magnitude unit: squares, then a restoring square root taking two radicand
// bits per cycle from a shift register, rounded and saturated. Uses afpd_pkg.
module afpd_sqrt #(
    parameter int SAMPLE_BITS = afpd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [SAMPLE_BITS-1:0]     i_i,
    input  logic [SAMPLE_BITS-1:0]     i_q,
    output logic                       o_done,
    output logic [afpd_pkg::MAG_W-1:0] o_mag
);
    localparam int SB  = SAMPLE_BITS;
    localparam int RW  = 2 * SB;
    localparam int RMW = SB + 3;
    localparam int WW  = SB + 17;

    logic signed [SB-1:0]       r_si, r_sq;
    logic signed [RW-1:0]       r_pi, r_pq;
    logic [RW-1:0]              r_rad;
    logic [RMW-1:0]             r_rem, rem_sh, trial;
    logic [SB:0]                r_root;
    logic [afpd_pkg::CNT_W-1:0] r_cnt;
    logic                       r_sqr, r_add, r_run, r_fin, r_done;
    logic [WW-1:0]              root_w;

    assign rem_sh = {r_rem[RMW-3:0], r_rad[RW-1 -: 2]};
    assign trial  = {r_root[RMW-3:0], 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqr  <= 1'b0;
            r_add  <= 1'b0;
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_sqr  <= i_start;
            r_add  <= r_sqr;
            r_fin  <= r_run && (r_cnt == afpd_pkg::CNT_W'(SB - 1));
            r_done <= r_fin;
            if (r_add) begin
                r_run <= 1'b1;
            end else if (r_run && (r_cnt == afpd_pkg::CNT_W'(SB - 1))) begin
                r_run <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_si <= $signed(i_i);
            r_sq <= $signed(i_q);
        end
        if (r_sqr) begin
            r_pi <= RW'(r_si) * RW'(r_si);
            r_pq <= RW'(r_sq) * RW'(r_sq);
        end
        if (r_add) begin
            r_rad  <= r_pi + r_pq;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= '0;
        end else if (r_run) begin
            r_rad <= {r_rad[RW-3:0], 2'b00};
            r_cnt <= r_cnt + 1'b1;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[SB-1:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[SB-1:0], 1'b0};
            end
        end else if (r_fin) begin
            if (r_rem > RMW'(r_root)) begin
                r_root <= r_root + 1'b1;
            end
        end
    end

    assign root_w = WW'(r_root);
    assign o_mag  = (root_w > WW'(17'h0FFFF)) ? 16'hFFFF : root_w[15:0];
    assign o_done = r_done;

endmodule

@@ hw/rtl/afpd_smul.sv @@
// Bit-serial signed gain multiplier: Q0.16 phase times Q16.16 gain, one
// multiplier bit per cycle, floored to Q16.16. Uses afpd_pkg.
module afpd_smul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [afpd_pkg::PHASE_W-1:0]  i_mplr,
    input  logic [afpd_pkg::GAIN_W-1:0]   i_mcand,
    output logic                          o_done,
    output logic [afpd_pkg::GAIN_W-1:0]   o_prod
);
    localparam int PW = afpd_pkg::PHASE_W;
    localparam int AW = afpd_pkg::ACC_W;

    logic [PW-1:0]              r_mp;
    logic [AW-1:0]              r_mc, r_acc;
    logic [afpd_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == afpd_pkg::CNT_W'(PW - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // sign bit of the multiplier carries negative weight
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mp  <= i_mplr;
            r_mc  <= AW'($signed(i_mcand));
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_mp  <= {1'b0, r_mp[PW-1:1]};
            r_mc  <= {r_mc[AW-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
            if (r_mp[0]) begin
                r_acc <= (r_cnt == afpd_pkg::CNT_W'(PW - 1)) ? r_acc - r_mc : r_acc + r_mc;
            end
        end
    end

    // 16x32 product shifted by 16 always fits 32 bits; truncation is floor
    assign o_prod = r_acc[AW-1:16];
    assign o_done = r_done;

endmodule

@@ hw/rtl/am_fm_pm_demodulator.sv @@
// An accepted item passes the CORDIC, which rotates once per cycle, alongside
// the square root, which retires one result bit per cycle; then both gain
// products run bit-serially over the 16 phase bits, and the result is
// registered once the output register is free. The next item is taken only
// after that. One item is in work at a time; a finished result waits in the
// output register while the next item is taken. Writing initial_phase also
// loads the stored previous phase.
// Depends on afpd_pkg, afpd_cordic, afpd_sqrt and afpd_smul.
module am_fm_pm_demodulator #(
    parameter int SAMPLE_BITS   = afpd_pkg::SAMPLE_BITS_DEF,
    parameter int CORDIC_STAGES = afpd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [SAMPLE_BITS-1:0]         i_sample_i,
    input  logic [SAMPLE_BITS-1:0]         i_sample_q,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [afpd_pkg::MAG_W-1:0]     o_am_mag,
    output logic [afpd_pkg::GAIN_W-1:0]    o_pm_phase,
    output logic [afpd_pkg::GAIN_W-1:0]    o_fm_freq,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [afpd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [afpd_pkg::GAIN_W-1:0]    i_cfg_data
);
    afpd_pkg::t_state r_state, n_state;

    logic [afpd_pkg::GAIN_W-1:0]  r_freq_gain, r_phase_gain, prod_p, prod_f;
    logic [afpd_pkg::PHASE_W-1:0] r_prev, phase, diff;
    logic [afpd_pkg::MAG_W-1:0]   mag;
    logic                         r_cdone, r_sdone, r_ovalid;
    logic                         cdone, sdone, done_p, done_f;
    logic                         in_acc, calc_end, mul_start, load, cfg_wr;

    assign in_acc = i_in_valid && !o_in_stall;
    assign cfg_wr = i_cfg_valid && o_cfg_ready;
    assign diff   = phase - r_prev;

    afpd_cordic #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(in_acc),
        .i_i    (i_sample_i),
        .i_q    (i_sample_q),
        .o_done (cdone),
        .o_phase(phase)
    );

    afpd_sqrt #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(in_acc),
        .i_i    (i_sample_i),
        .i_q    (i_sample_q),
        .o_done (sdone),
        .o_mag  (mag)
    );

    afpd_smul u_mul_pm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_mplr (phase),
        .i_mcand(r_phase_gain),
        .o_done (done_p),
        .o_prod (prod_p)
    );

    afpd_smul u_mul_fm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(mul_start),
        .i_mplr (diff),
        .i_mcand(r_freq_gain),
        .o_done (done_f),
        .o_prod (prod_f)
    );

    assign calc_end = (r_cdone || cdone) && (r_sdone || sdone);

    always_comb begin
        n_state = r_state;
        case (r_state)
            afpd_pkg::ST_IDLE: if (in_acc)   n_state = afpd_pkg::ST_CALC;
            afpd_pkg::ST_CALC: if (calc_end) n_state = afpd_pkg::ST_MUL;
            afpd_pkg::ST_MUL:  if (done_p)   n_state = afpd_pkg::ST_LOAD;
            afpd_pkg::ST_LOAD: if (load)     n_state = afpd_pkg::ST_IDLE;
            default:                         n_state = afpd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        mul_start  = 1'b0;
        load       = 1'b0;
        case (r_state)
            afpd_pkg::ST_IDLE: o_in_stall = 1'b0;
            afpd_pkg::ST_CALC: mul_start  = calc_end;
            afpd_pkg::ST_LOAD: load       = !r_ovalid || !i_out_stall;
            default: ;
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= afpd_pkg::ST_IDLE;
            r_cdone      <= 1'b0;
            r_sdone      <= 1'b0;
            r_ovalid     <= 1'b0;
            r_freq_gain  <= afpd_pkg::GAIN_RESET;
            r_phase_gain <= afpd_pkg::GAIN_RESET;
            r_prev       <= '0;
        end else begin
            r_state <= n_state;
            if (in_acc || mul_start) begin
                r_cdone <= 1'b0;
                r_sdone <= 1'b0;
            end else begin
                if (cdone) r_cdone <= 1'b1;
                if (sdone) r_sdone <= 1'b1;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (mul_start) begin
                r_prev <= phase;
            end
            if (cfg_wr) begin
                case (i_cfg_index)
                    afpd_pkg::CFG_FREQ_GAIN:     r_freq_gain  <= i_cfg_data;
                    afpd_pkg::CFG_PHASE_GAIN:    r_phase_gain <= i_cfg_data;
                    afpd_pkg::CFG_INITIAL_PHASE: r_prev <= i_cfg_data[afpd_pkg::PHASE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_am_mag   <= mag;
            o_pm_phase <= prod_p;
            o_fm_freq  <= prod_f;
        end
    end

    a_accept_starts_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == afpd_pkg::ST_CALC)
        else $error("accepted item did not start calculation");

    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_p == done_f)
        else $error("gain multipliers out of step");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == afpd_pkg::ST_LOAD && r_ovalid && i_out_stall)
        |=> r_state == afpd_pkg::ST_LOAD && r_ovalid)
        else $error("result loaded over a stalled item");

    a_no_start_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_start |-> r_state == afpd_pkg::ST_CALC && !in_acc)
        else $error("multiply started outside calculation");

endmodule
